FILE: rtl/indexed_list_engine_core_macros.svh
// Assertion macros for the indexed list engine RTL.
`ifndef INDEXED_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ILST_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ILST_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ILST_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define ILST_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/ilst_pkg.sv
// Types, codes and defaults shared by the indexed list engine.
package ilst_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Request opcodes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_GET    = 3'd5;
  localparam logic [2:0] OP_FIND   = 3'd6;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BADPOS   = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [6:0]         position;
    logic signed [31:0] data_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [5:0]         found_position;
    logic [6:0]         entry_count;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
  } out_res_t;

endpackage

FILE: rtl/ilst_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ilst_ram #(
  parameter int WIDTH = ilst_pkg::VALUE_BITS_DEF,
  parameter int DEPTH = ilst_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ilst_ctrl.sv
// Sequencer for the indexed list: decode, memory walk, write-back and end refresh.
`include "indexed_list_engine_core_macros.svh"

module ilst_ctrl #(
  parameter int CAPACITY   = ilst_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ilst_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ilst_pkg::in_req_t     in_req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ilst_pkg::out_res_t    res,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [VALUE_BITS-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [VALUE_BITS-1:0] mem_rdata
);

  localparam int CMPW = (CW > 7) ? CW : 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_RF0   = 7'b0001000,
    S_RF1   = 7'b0010000,
    S_RF2   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         tgt_r, tgt_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [VALUE_BITS-1:0] first_r, first_nxt;
  logic [VALUE_BITS-1:0] last_r, last_nxt;
  logic [VALUE_BITS-1:0] readv_r, readv_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [AW-1:0]         fpos_r, fpos_nxt;
  logic [AW-1:0]         walk_addr_r, walk_addr_nxt;
  logic [CW-1:0]         walk_left_r, walk_left_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         pend_addr_r, pend_addr_nxt;

  logic                  in_fire;
  logic [CMPW-1:0]       pos_w;
  logic [CMPW-1:0]       cnt_w;
  logic                  full;
  logic [VALUE_BITS-1:0] in_val;
  logic [AW-1:0]         in_pos;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign pos_w    = CMPW'(in_req.position);
  assign cnt_w    = CMPW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign in_val   = VALUE_BITS'(64'($unsigned(in_req.data_value)));
  assign in_pos   = AW'(in_req.position);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    tgt_nxt       = tgt_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    readv_nxt     = readv_r;
    status_nxt    = status_r;
    fpos_nxt      = fpos_r;
    walk_addr_nxt = walk_addr_r;
    walk_left_nxt = walk_left_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    mem_we        = 1'b0;
    mem_waddr     = tgt_r;
    mem_wdata     = val_r;
    mem_re        = 1'b0;
    mem_raddr     = walk_addr_r;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_req.opcode;
          pos_nxt    = in_pos;
          val_nxt    = in_val;
          status_nxt = ilst_pkg::STAT_OK;
          readv_nxt  = '0;
          fpos_nxt   = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
          case (in_req.opcode)
            ilst_pkg::OP_APPEND: begin
              if (full) begin
                status_nxt = ilst_pkg::STAT_FULL;
              end else begin
                tgt_nxt   = AW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_WRITE;
              end
            end
            ilst_pkg::OP_INSERT: begin
              if (pos_w > cnt_w) begin
                status_nxt = ilst_pkg::STAT_BADPOS;
              end else if (full) begin
                status_nxt = ilst_pkg::STAT_FULL;
              end else begin
                tgt_nxt       = in_pos;
                count_nxt     = count_r + CW'(1);
                walk_addr_nxt = AW'(count_r - CW'(1));
                walk_left_nxt = CW'(cnt_w - pos_w);
                state_nxt     = S_WALK;
              end
            end
            ilst_pkg::OP_SET: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ilst_pkg::STAT_BADPOS;
              end else begin
                tgt_nxt   = in_pos;
                state_nxt = S_WRITE;
              end
            end
            ilst_pkg::OP_REMOVE: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ilst_pkg::STAT_BADPOS;
              end else begin
                count_nxt     = count_r - CW'(1);
                walk_addr_nxt = in_pos;
                walk_left_nxt = CW'(cnt_w - pos_w);
                state_nxt     = S_WALK;
              end
            end
            ilst_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            ilst_pkg::OP_GET: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ilst_pkg::STAT_BADPOS;
              end else begin
                walk_addr_nxt = in_pos;
                walk_left_nxt = CW'(1);
                state_nxt     = S_WALK;
              end
            end
            ilst_pkg::OP_FIND: begin
              status_nxt    = ilst_pkg::STAT_NOTFOUND;
              walk_addr_nxt = '0;
              walk_left_nxt = count_r;
              state_nxt     = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // issue the next read of the walk
        if (walk_left_r != '0) begin
          mem_re        = 1'b1;
          mem_raddr     = walk_addr_r;
          walk_left_nxt = walk_left_r - CW'(1);
          walk_addr_nxt = (op_r == ilst_pkg::OP_INSERT) ? (walk_addr_r - AW'(1))
                                                        : (walk_addr_r + AW'(1));
        end
        pend_nxt      = (walk_left_r != '0);
        pend_addr_nxt = walk_addr_r;

        // handle the word read in the previous cycle
        if (pend_r) begin
          case (op_r)
            ilst_pkg::OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_r + AW'(1);
              mem_wdata = mem_rdata;
            end
            ilst_pkg::OP_REMOVE: begin
              if (pend_addr_r == pos_r) begin
                readv_nxt = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_r - AW'(1);
                mem_wdata = mem_rdata;
              end
            end
            ilst_pkg::OP_GET: begin
              readv_nxt = mem_rdata;
            end
            ilst_pkg::OP_FIND: begin
              if (mem_rdata == val_r) begin
                status_nxt = ilst_pkg::STAT_OK;
                fpos_nxt   = pend_addr_r;
                pend_nxt   = 1'b0;
                state_nxt  = S_DONE;
              end
            end
            default: begin
            end
          endcase
        end

        if ((walk_left_r == '0) && !pend_r) begin
          case (op_r)
            ilst_pkg::OP_INSERT: state_nxt = S_WRITE;
            ilst_pkg::OP_REMOVE: state_nxt = S_RF0;
            default:             state_nxt = S_DONE;
          endcase
        end
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r;
        mem_wdata = val_r;
        state_nxt = S_RF0;
      end

      S_RF0: begin
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = S_RF1;
        end
      end

      S_RF1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(count_r - CW'(1));
        first_nxt = mem_rdata;
        state_nxt = S_RF2;
      end

      S_RF2: begin
        last_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status         = status_r;
    res.read_value     = $signed(32'(64'(readv_r)));
    res.found_position = 6'(fpos_r);
    res.entry_count    = 7'(count_r);
    res.first_value    = (count_r == '0) ? '0 : $signed(32'(64'(first_r)));
    res.last_value     = (count_r == '0) ? '0 : $signed(32'(64'(last_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    tgt_r       <= tgt_nxt;
    val_r       <= val_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    readv_r     <= readv_nxt;
    status_r    <= status_nxt;
    fpos_r      <= fpos_nxt;
    walk_addr_r <= walk_addr_nxt;
    walk_left_r <= walk_left_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  `ILST_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same entry")
  `ILST_ASSERT_IMP(a_count_bound, clk, rst_n, state_r == S_DONE, count_r <= CW'(CAPACITY), "entry count above capacity")
  `ILST_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_fire, state_r != S_IDLE, "request accepted but sequencer idle")

endmodule

FILE: rtl/indexed_list_engine_core.sv
// Top level of the indexed list engine: list memory, sequencer and result register.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid / in_stall   ilst_pkg::in_req_t  (opcode, position, data_value)
//   out_     result     out_valid / out_stall ilst_pkg::out_res_t (status ... last_value)
//
// Each accepted request passes the sequencer before the result register loads: clear, unused
// opcodes and refused requests go straight to the result; get, insert, remove and find walk
// the entries one per cycle through the single read port of the memory; append, set and insert
// write the new value; append, set, insert and remove then refresh first and last values.
// Reset clears the entry count and the sequencer; the list memory is not cleared.
// Hold a result in the output register while out_stall is high; take the next request after.
module indexed_list_engine_core #(
  parameter int CAPACITY   = ilst_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ilst_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ilst_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ilst_pkg::out_res_t out_res
);

  localparam int AW = $clog2(CAPACITY);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  logic                  res_valid;
  logic                  res_ready;
  ilst_pkg::out_res_t    res;

  logic                  out_valid_r, out_valid_nxt;
  ilst_pkg::out_res_t    out_res_r;
  logic                  res_load;

  // List storage: one word per position, read data registered
  ilst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Decode, shift walks, search and first/last refresh
  ilst_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Take a new result whenever the output register is empty or being drained
  assign res_ready     = !out_valid_r || !out_stall;
  assign res_load      = res_valid && res_ready;
  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled; load only on handover
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
